// ===== rtl/core/masked_byte_pattern_scan_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbps assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbps assertion failed");

`endif

// ===== rtl/core/mbps_pkg.sv =====
package mbps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ADDR_W      = 64;
    localparam int POS_W       = 32;
    localparam int PAT_BYTES   = 16;   // bytes held in the pattern registers

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REGION_BASE    = 3'd0,
        REG_PATTERN_LOW    = 3'd1,
        REG_PATTERN_HIGH   = 3'd2,
        REG_CARE_MASK      = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_RESULT_OFFSET  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } result_t;

endpackage

// ===== rtl/core/masked_byte_pattern_scan.sv =====
// A byte is accepted into the input register; any result it produces is then written to the
// result register and offered on the master side.
// One byte per cycle unless a held result stalls; a byte passes one registered window compare.
// A result held on the master side while m_axis_tready is low stalls the input register.
// Reset (rst_n low, asynchronous) clears handshake state, position, match flag
// and all configuration registers to their documented values.
module masked_byte_pattern_scan #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    // byte stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
    input  logic                                s_axis_tlast,   // last_byte
    // result stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mbps_pkg::ADDR_W-1:0]         m_axis_tdata,   // [63:0] match_address
    output logic [0:0]                          m_axis_tuser    // [0] found
);

    import mbps_pkg::*;

    localparam int WIN_W = PATTERN_MAX * 8;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // configuration
    logic [ADDR_W-1:0]    region_base_reg;
    logic [63:0]          pattern_low_reg;
    logic [63:0]          pattern_high_reg;
    logic [15:0]          care_mask_reg;
    logic [4:0]           pattern_length_reg;
    logic [31:0]          result_offset_reg;
    logic [ADDR_W-1:0]    base_offset_reg;   // region_base + sign-extended offset

    // input register
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    // scan state
    logic [WIN_W-1:0]     window_reg;        // byte 0 is the newest
    logic [WIN_W-1:0]     window_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic                 done_reg;
    logic                 done_next;

    // result register
    logic                 res_valid_reg;
    result_t              res_reg;
    result_t              res_next;
    logic                 res_produce;

    logic                 proceed;
    logic [LEN_W-1:0]     len_eff;
    logic [LEN_W-1:0]     shift_bytes;
    logic [7:0]           pat_bytes [PAT_BYTES];
    logic [WIN_W-1:0]     rev_pat;
    logic [PATTERN_MAX-1:0] rev_care;
    logic [WIN_W-1:0]     align_pat;
    logic [PATTERN_MAX-1:0] align_care;
    logic [PATTERN_MAX-1:0] byte_ok;
    logic                 window_hit;
    logic                 pos_ok;
    logic [POS_W-1:0]     start_pos;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg    <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= 16'hFFFF;
            pattern_length_reg <= 5'd1;
            result_offset_reg  <= '0;
            base_offset_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_REGION_BASE:
                begin
                    region_base_reg <= cfg_data;
                    base_offset_reg <= cfg_data
                                     + {{32{result_offset_reg[31]}}, result_offset_reg};
                end
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_CARE_MASK:      care_mask_reg      <= cfg_data[15:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                REG_RESULT_OFFSET:
                begin
                    result_offset_reg <= cfg_data[31:0];
                    base_offset_reg   <= region_base_reg
                                       + {{32{cfg_data[31]}}, cfg_data[31:0]};
                end
                default: ;
            endcase
        end
    end

    // ---------------- pattern alignment ----------------
    always_comb
    begin
        if (pattern_length_reg == 5'd0)
            len_eff = LEN_W'(1);
        else if (32'(pattern_length_reg) > PATTERN_MAX)
            len_eff = LEN_W'(PATTERN_MAX);
        else
            len_eff = LEN_W'(pattern_length_reg);
    end

    assign shift_bytes = LEN_W'(PATTERN_MAX) - len_eff;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            pat_bytes[b]     = pattern_low_reg[b*8 +: 8];
            pat_bytes[b + 8] = pattern_high_reg[b*8 +: 8];
        end
    end

    // Reversed pattern: window slot i must equal pattern byte n-1-i, so after
    // reversal a right shift by (PATTERN_MAX - n) bytes lines it up. Slots at
    // or beyond n get care 0 from the zero fill.
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (PATTERN_MAX - 1 - k < PAT_BYTES)
            begin
                rev_pat[k*8 +: 8] = pat_bytes[4'(PATTERN_MAX - 1 - k)];
                rev_care[k]       = care_mask_reg[4'(PATTERN_MAX - 1 - k)];
            end
            else
            begin
                rev_pat[k*8 +: 8] = 8'h00;
                rev_care[k]       = 1'b0;
            end
        end
    end

    assign align_pat  = rev_pat >> {shift_bytes, 3'b000};
    assign align_care = rev_care >> shift_bytes;

    // ---------------- input register ----------------
    assign proceed       = in_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // ---------------- window compare ----------------
    assign window_next = WIN_W'({window_reg, in_byte_reg});

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
            byte_ok[i] = !align_care[i] || (window_next[i*8 +: 8] == align_pat[i*8 +: 8]);
    end

    assign window_hit = &byte_ok;
    assign pos_ok     = (pos_reg != '1) && (({1'b0, pos_reg} + 33'd1) >= 33'(len_eff));
    assign start_pos  = pos_reg + 32'd1 - 32'(len_eff);

    always_comb
    begin
        pos_next         = pos_reg;
        done_next        = done_reg;
        res_produce      = 1'b0;
        res_next.found   = 1'b0;
        res_next.address = '0;
        priority if (done_reg)
        begin
            if (in_last_reg)
            begin
                pos_next  = '0;
                done_next = 1'b0;
            end
        end
        else if (pos_ok && window_hit)
        begin
            res_produce      = 1'b1;
            res_next.found   = 1'b1;
            res_next.address = base_offset_reg + ADDR_W'(start_pos);
            pos_next         = in_last_reg ? '0 : pos_reg + 32'd1;
            done_next        = !in_last_reg;
        end
        else if (in_last_reg)
        begin
            res_produce = 1'b1;
            pos_next    = '0;
        end
        else
        begin
            pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 32'd1;
        end
    end

    // Window bytes are only compared once the region has supplied n of them,
    // so the window itself needs no clearing.
    always_ff @(posedge clk)
    begin
        if (proceed && !done_reg)
            window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (proceed)
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (proceed && res_produce)
            res_valid_reg <= 1'b1;
        else if (m_axis_tready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proceed && res_produce)
            res_reg <= res_next;
    end

    assign m_axis_tvalid   = res_valid_reg;
    assign m_axis_tdata    = res_reg.address;
    assign m_axis_tuser[0] = res_reg.found;

    // ---------------- assertions ----------------
`include "masked_byte_pattern_scan_macros.svh"

    `MBPS_ASSERT_NOW(a_notfound_zero_addr, clk, rst_n,
                     res_valid_reg && !res_reg.found, res_reg.address == '0)
    `MBPS_ASSERT_NOW(a_done_has_pos, clk, rst_n, done_reg, pos_reg != '0)
    `MBPS_ASSERT_NOW(a_done_silent, clk, rst_n, proceed && done_reg, !res_produce)
    `MBPS_ASSERT_NEXT(a_match_sets_done, clk, rst_n,
                      proceed && !done_reg && pos_ok && window_hit && !in_last_reg, done_reg)
    `MBPS_ASSERT_NEXT(a_stalled_item_kept, clk, rst_n,
                      in_valid_reg && !proceed, in_valid_reg)

endmodule
